### rtl/rti_pkg.sv
// shared constants, types and helpers for the radix trie insert/lookup block
// no dependencies
`default_nettype none
package rti_pkg;
	localparam int POOL_NODES = 256;
	localparam int NODE_W     = $clog2(POOL_NODES);
	localparam int ADDR_W     = NODE_W + 8;
	localparam int FREE_W     = $clog2(POOL_NODES + 1);
	localparam int DEPTH      = POOL_NODES * 256;
	localparam int LEVEL_W    = 2;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEVEL_W-1:0] level_t;

	localparam node_t LEAF_MARK = node_t'(1);
	localparam level_t LEAF_LEVEL = level_t'(3);

	function automatic logic [7:0] key_byte(input logic [31:0] key, input level_t level);
		logic [7:0] b;
		case (level)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			default: b = key[7:0];
		endcase
		return b;
	endfunction
endpackage
`default_nettype wire

### rtl/rti_ram.sv
// single-port synchronous node store, registered read
// depends on rti_pkg
`default_nettype none
module rti_ram (
	input  wire logic           clk,
	input  wire logic           we,
	input  wire rti_pkg::addr_t addr,
	input  wire rti_pkg::node_t wdata,
	output rti_pkg::node_t      rdata
);
	import rti_pkg::*;

	node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### rtl/radix_trie_insert_lookup.sv
// radix trie insert/lookup: each item takes, from accept to result transfer, one to four
// dependent node reads, or on a new insert the read that misses plus the writes below it,
// five in all, all through the single port of the node store; one item at a time
// result strobe done is high one cycle; the receiver cannot stall it
// after reset busy stays high while the store is cleared
// depends on rti_pkg and rti_ram
`default_nettype none
module radix_trie_insert_lookup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        mode,
	input  wire logic [31:0] key,
	output logic             busy,
	output logic             done,
	output logic             present,
	output logic             pool_full
);
	import rti_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0]        state_q;
	addr_t             clr_q;
	logic              mode_q;
	logic [31:0]       key_q;
	level_t            level_q;
	node_t             node_q;
	logic [FREE_W-1:0] free_q;

	logic  mem_we;
	addr_t mem_addr;
	node_t mem_wdata;
	node_t mem_rdata;

	logic              child_ok;
	logic              hit;
	logic [1:0]        missing;
	logic [FREE_W:0]   need;
	logic              no_room;

	rti_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign busy     = (state_q != ST_IDLE);
	assign child_ok = (mem_rdata != '0) &&
		((NODE_W+1)'(mem_rdata) < (NODE_W+1)'(POOL_NODES));
	assign hit      = (mem_rdata != '0);
	assign missing  = 2'(LEAF_LEVEL - level_q);
	assign need     = {1'b0, free_q} + (FREE_W+1)'(missing);
	assign no_room  = need > (FREE_W+1)'(POOL_NODES);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		mem_addr  = {node_t'(0), key[31:24]};
		case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				mem_addr = {node_t'(0), key[31:24]};
			end
			ST_READ: begin
				mem_addr = {mem_rdata, key_byte(key_q, level_q + level_t'(1))};
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = {node_q, key_byte(key_q, level_q)};
				mem_wdata = (level_q == LEAF_LEVEL) ? LEAF_MARK : free_q[NODE_W-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			free_q    <= FREE_W'(1);
			done      <= 1'b0;
			present   <= 1'b0;
			pool_full <= 1'b0;
			level_q   <= '0;
			node_q    <= '0;
			mode_q    <= 1'b0;
			key_q     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						key_q   <= key;
						level_q <= '0;
						node_q  <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (level_q != LEAF_LEVEL && child_ok) begin
						node_q  <= mem_rdata;
						level_q <= level_q + level_t'(1);
					end else begin
						if (level_q == LEAF_LEVEL && hit) begin
							done      <= 1'b1;
							present   <= 1'b1;
							pool_full <= 1'b0;
							state_q   <= ST_IDLE;
						end else if (!mode_q) begin
							done      <= 1'b1;
							present   <= 1'b0;
							pool_full <= 1'b0;
							state_q   <= ST_IDLE;
						end else if (no_room) begin
							done      <= 1'b1;
							present   <= 1'b0;
							pool_full <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (level_q == LEAF_LEVEL) begin
						done      <= 1'b1;
						present   <= 1'b0;
						pool_full <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						node_q  <= free_q[NODE_W-1:0];
						free_q  <= free_q + FREE_W'(1);
						level_q <= level_q + level_t'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe without a transfer in progress");

	a_full_not_present: assert property (@(posedge clk) disable iff (!arst_n)
		done && pool_full |-> !present)
		else $error("pool_full raised together with present");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q != '0) && ({1'b0, free_q} <= (FREE_W+1)'(POOL_NODES)))
		else $error("free node counter out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");
endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for radix_trie_insert_lookup: directed and random insert/lookup traffic,
// predicted by a behavioral trie and compared per result; depends on rti_pkg and the block's RTL
module testbench;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic present;
		logic pool_full;
	} trie_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic mode;
	logic [31:0] key;
	logic busy;
	logic done;
	logic present;
	logic pool_full;

	rti_pkg::node_t trie_nodes [rti_pkg::DEPTH];
	logic [rti_pkg::FREE_W-1:0] next_free;
	trie_result_t expected_results [$];
	logic [31:0] stored_keys [$];
	int error_count;
	int cycle_count;
	int pool_full_hits;
	int sender_idle_pct;

	radix_trie_insert_lookup uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.key(key),
		.busy(busy),
		.done(done),
		.present(present),
		.pool_full(pool_full)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// walks the trie for one item and applies an insert, returns the expected result fields
	function automatic void trie_apply(input logic is_insert, input logic [31:0] k,
			output logic hit, output logic full);
		int unsigned node;
		int unsigned depth;
		int unsigned child;
		node = 0;
		depth = 0;
		hit = 1'b0;
		full = 1'b0;
		while (depth < 3) begin
			child = trie_nodes[node * 256 + k[31 - 8 * depth -: 8]];
			if (child == 0 || child >= rti_pkg::POOL_NODES)
				break;
			node = child;
			depth++;
		end
		if (depth == 3)
			hit = trie_nodes[node * 256 + k[7:0]] != '0;
		if (is_insert && !hit) begin
			if (next_free + (3 - depth) > rti_pkg::POOL_NODES) begin
				full = 1'b1;
			end else begin
				while (depth < 3) begin
					trie_nodes[node * 256 + k[31 - 8 * depth -: 8]] = rti_pkg::node_t'(next_free);
					node = next_free;
					next_free++;
					depth++;
				end
				trie_nodes[node * 256 + k[7:0]] = rti_pkg::LEAF_MARK;
			end
		end
	endfunction

	// mostly keys that share a path with stored ones, so deep levels and the leaf are reached
	function automatic logic [31:0] pick_key();
		int r;
		logic [31:0] base;
		logic [31:0] rnd;
		r = $urandom_range(99);
		rnd = $urandom;
		if (stored_keys.size() == 0 || r < 8)
			return rnd;
		base = stored_keys[$urandom_range(stored_keys.size() - 1)];
		if (r < 16)
			return {base[31:24], rnd[23:0]};
		if (r < 26)
			return {base[31:16], rnd[15:0]};
		if (r < 70)
			return {base[31:8], rnd[7:0]};
		return base;
	endfunction

	task automatic send_item(input logic is_insert, input logic [31:0] k);
		logic hit;
		logic full;
		int gap;
		trie_result_t exp_item;
		start <= 1'b1;
		mode <= is_insert;
		key <= k;
		do @(posedge clk); while (busy);
		trie_apply(is_insert, k, hit, full);
		exp_item.present = hit;
		exp_item.pool_full = full;
		expected_results = {expected_results, exp_item};
		if (full)
			pool_full_hits++;
		if (is_insert && !hit && !full)
			stored_keys = {stored_keys, k};
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		trie_result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				exp_res = expected_results.pop_front();
				if (present !== exp_res.present)
					report_mismatch($sformatf("present got %b want %b", present,
						exp_res.present));
				if (pool_full !== exp_res.pool_full)
					report_mismatch($sformatf("pool_full got %b want %b", pool_full,
						exp_res.pool_full));
			end
		end
	end

	task automatic test_empty_trie();
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h8000_0001);
	endtask

	task automatic test_key_extremes();
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'hFFFF_FFFF);
		// already present: nothing changes
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b1, 32'hFFFF_FFFF);
	endtask

	task automatic test_shared_prefixes();
		send_item(1'b1, 32'h1234_5678);
		send_item(1'b1, 32'h1234_5679);
		send_item(1'b1, 32'h1234_00FF);
		send_item(1'b1, 32'h12FF_0000);
		send_item(1'b0, 32'h1234_5600);
		send_item(1'b0, 32'h1234_0000);
		send_item(1'b0, 32'h1300_0000);
		send_item(1'b0, 32'h1234_5679);
		send_item(1'b0, 32'h12FF_0000);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		sender_idle_pct = idle_pct;
		repeat (count)
			send_item($urandom_range(99) < 55, pick_key());
	endtask

	// keeps inserting until the node pool has refused eight inserts or 400 tries, then mixed items
	task automatic test_pool_exhaustion();
		int tries;
		tries = 0;
		sender_idle_pct = 30;
		while (pool_full_hits < 8 && tries < 400) begin
			send_item(1'b1, ($urandom_range(1) != 0) ? $urandom : pick_key());
			tries++;
		end
		repeat (20)
			send_item(1'($urandom_range(1)), pick_key());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		key = '0;
		error_count = 0;
		cycle_count = 0;
		pool_full_hits = 0;
		sender_idle_pct = 0;
		next_free = 1;
		foreach (trie_nodes[i])
			trie_nodes[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_trie();
		test_key_extremes();
		test_shared_prefixes();
		test_random_traffic(30, 560);
		wait_drained();
		test_random_traffic(62, 560);
		wait_drained();
		test_random_traffic(0, 560);
		test_pool_exhaustion();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
